// ===== design/qcpm_pkg.sv =====
// Shared types, constants and coefficient tables for the quadratic camera point mapper.
// Used by qcpm_axis and quadratic_camera_point_mapper_core; depends on nothing.
package qcpm_pkg;

    localparam int FRAC_BITS = 8;

    localparam int IN_W    = 17;
    localparam int SQ_W    = 2 * IN_W;
    localparam int C0_W    = 37;
    localparam int C1_W    = 32;
    localparam int CQ_W    = 24;
    localparam int COEF_FB = 30;

    localparam int LIN_BASE = (C0_W + FRAC_BITS > C1_W + IN_W) ?
                              (C0_W + FRAC_BITS) : (C1_W + IN_W);
    localparam int LIN_W    = LIN_BASE + 2;
    localparam int QUAD_W   = CQ_W + SQ_W + 2;
    localparam int SUM_BASE = (LIN_W > QUAD_W - FRAC_BITS) ? LIN_W : (QUAD_W - FRAC_BITS);
    localparam int SUM_W    = SUM_BASE + 1;
    localparam int RES_W    = SUM_W - COEF_FB;

    localparam int X_OUT_W = 16;
    localparam int Y_OUT_W = 15;

    localparam int IN_LIM_X  = 140 * (1 << FRAC_BITS);
    localparam int IN_LIM_Y  = 110 * (1 << FRAC_BITS);
    localparam int OUT_LIM_X = 94 * (1 << FRAC_BITS);
    localparam int OUT_LIM_Y = 60 * (1 << FRAC_BITS);

    localparam logic [1:0] CAM_FRONT  = 2'd0;
    localparam logic [1:0] CAM_CENTER = 2'd1;
    localparam logic [1:0] CAM_BACK   = 2'd2;
    localparam logic [1:0] CAM_REJECT = 2'd3;

    typedef struct packed {
        logic signed [C0_W-1:0] c0;
        logic signed [C1_W-1:0] c1;
        logic signed [C1_W-1:0] c2;
        logic signed [CQ_W-1:0] c3;
        logic signed [CQ_W-1:0] c4;
        logic signed [CQ_W-1:0] c5;
    } coef_set_t;

    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
    } stage_en_t;

    // decimal scales for rounding coefficients to Q30, ties away from zero
    localparam logic [95:0] DEC_8  = 96'd100000000;
    localparam logic [95:0] DEC_9  = 96'd1000000000;
    localparam logic [95:0] DEC_10 = 96'd10000000000;
    localparam logic [95:0] DEC_11 = 96'd100000000000;
    localparam logic [95:0] DEC_12 = 96'd1000000000000;
    localparam logic [95:0] DEC_13 = 96'd10000000000000;
    localparam logic [95:0] DEC_14 = 96'd100000000000000;

    localparam coef_set_t COEF_FRONT_X = '{
        c0: C0_W'(((96'd4598873713 << COEF_FB) + (DEC_9 >> 1)) / DEC_9),
        c1: C1_W'(((96'd1112662896 << COEF_FB) + (DEC_9 >> 1)) / DEC_9),
        c2: C1_W'(((96'd3961500727 << COEF_FB) + (DEC_11 >> 1)) / DEC_11),
        c3: CQ_W'(96'd0 - ((96'd9593892413 << COEF_FB) + (DEC_13 >> 1)) / DEC_13),
        c4: CQ_W'(((96'd3638791921 << COEF_FB) + (DEC_12 >> 1)) / DEC_12),
        c5: CQ_W'(((96'd1953756646 << COEF_FB) + (DEC_13 >> 1)) / DEC_13)
    };

    localparam coef_set_t COEF_FRONT_Y = '{
        c0: C0_W'(((96'd5776555674 << COEF_FB) + (DEC_8 >> 1)) / DEC_8),
        c1: C1_W'(96'd0 - ((96'd4623574104 << COEF_FB) + (DEC_11 >> 1)) / DEC_11),
        c2: C1_W'(((96'd7418767472 << COEF_FB) + (DEC_10 >> 1)) / DEC_10),
        c3: CQ_W'(96'd0 - ((96'd3921243931 << COEF_FB) + (DEC_12 >> 1)) / DEC_12),
        c4: CQ_W'(((96'd9845932112 << COEF_FB) + (DEC_14 >> 1)) / DEC_14),
        c5: CQ_W'(96'd0 - ((96'd3075629357 << COEF_FB) + (DEC_12 >> 1)) / DEC_12)
    };

    localparam coef_set_t COEF_BACK_X = '{
        c0: C0_W'(96'd0 - ((96'd1182017882 << COEF_FB) + (DEC_8 >> 1)) / DEC_8),
        c1: C1_W'(96'd0 - ((96'd1112148871 << COEF_FB) + (DEC_9 >> 1)) / DEC_9),
        c2: C1_W'(((96'd5965474006 << COEF_FB) + (DEC_11 >> 1)) / DEC_11),
        c3: CQ_W'(((96'd1312940857 << COEF_FB) + (DEC_12 >> 1)) / DEC_12),
        c4: CQ_W'(((96'd3580014712 << COEF_FB) + (DEC_12 >> 1)) / DEC_12),
        c5: CQ_W'(96'd0 - ((96'd5696456455 << COEF_FB) + (DEC_13 >> 1)) / DEC_13)
    };

    localparam coef_set_t COEF_BACK_Y = '{
        c0: C0_W'(((96'd5842283122 << COEF_FB) + (DEC_8 >> 1)) / DEC_8),
        c1: C1_W'(96'd0 - ((96'd4773654331 << COEF_FB) + (DEC_11 >> 1)) / DEC_11),
        c2: C1_W'(96'd0 - ((96'd7173750546 << COEF_FB) + (DEC_10 >> 1)) / DEC_10),
        c3: CQ_W'(96'd0 - ((96'd3842275563 << COEF_FB) + (DEC_12 >> 1)) / DEC_12),
        c4: CQ_W'(96'd0 - ((96'd4617931 << COEF_FB) + (DEC_10 >> 1)) / DEC_10),
        c5: CQ_W'(96'd0 - ((96'd5021741498 << COEF_FB) + (DEC_12 >> 1)) / DEC_12)
    };

    function automatic coef_set_t coef_sel(input logic back, input logic axis_y);
        coef_set_t c;
        case ({back, axis_y})
            2'b00:   c = COEF_FRONT_X;
            2'b01:   c = COEF_FRONT_Y;
            2'b10:   c = COEF_BACK_X;
            2'b11:   c = COEF_BACK_Y;
            default: c = COEF_FRONT_X;
        endcase
        return c;
    endfunction

endpackage

// ===== design/quadratic_camera_point_mapper_core.sv =====
// Top level of the quadratic camera point mapper: handshake, pipeline control,
// window checks and pass-through select. Depends on qcpm_pkg and qcpm_axis.
//
// Maps a center-camera point (signed, 8 fractional bits) into the front, center
// or back camera image. The block takes one word per cycle while in_stall is low
// and returns one word for every word taken, in order. out_valid rises when the
// output register loads a result.
// The word passes five registers on the way: an input register, a square/linear
// product stage, a coefficient product stage, a quadratic sum stage and the
// output register. Every stage holds one word; a
// stage advances whenever the stage after it is empty or advancing, so in_stall
// rises only when all five stages are full and out_stall is high. point_valid is
// low, with zero coordinates, for camera index 3 or a point outside either window.
module quadratic_camera_point_mapper_core (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     in_valid,
    output logic                                     in_stall,
    input  logic [1:0]                               camera_index,
    input  logic signed [qcpm_pkg::IN_W-1:0]         center_x,
    input  logic signed [qcpm_pkg::IN_W-1:0]         center_y,
    output logic                                     out_valid,
    input  logic                                     out_stall,
    output logic                                     point_valid,
    output logic signed [qcpm_pkg::X_OUT_W-1:0]      projected_x,
    output logic signed [qcpm_pkg::Y_OUT_W-1:0]      projected_y
);

    logic v_s1_reg, v_s2_reg, v_s3_reg, v_s4_reg, v_out_reg;
    logic en_s1, en_out;
    qcpm_pkg::stage_en_t en;

    logic [1:0]                           cam_s1_reg, cam_s2_reg, cam_s3_reg, cam_s4_reg;
    logic                                 ok_s1_reg, ok_s2_reg, ok_s3_reg, ok_s4_reg;
    logic                                 ok_s1_next;
    logic signed [qcpm_pkg::IN_W-1:0]     x_s1_reg, x_s2_reg, x_s3_reg, x_s4_reg;
    logic signed [qcpm_pkg::IN_W-1:0]     y_s1_reg, y_s2_reg, y_s3_reg, y_s4_reg;
    logic signed [qcpm_pkg::SQ_W-1:0]     xx_s2_reg, xy_s2_reg, yy_s2_reg;
    logic signed [qcpm_pkg::SQ_W-1:0]     xx_s2_next, xy_s2_next, yy_s2_next;

    qcpm_pkg::coef_set_t cset_x_s1, cset_y_s1, cset_x_s2, cset_y_s2;
    logic signed [qcpm_pkg::RES_W-1:0]    res_x, res_y, px_sel, py_sel;
    logic                                 ok_out;

    logic                                 point_valid_reg, point_valid_next;
    logic signed [qcpm_pkg::X_OUT_W-1:0]  projected_x_reg, projected_x_next;
    logic signed [qcpm_pkg::Y_OUT_W-1:0]  projected_y_reg, projected_y_next;

    // advance a stage when it is empty or the next stage advances
    always_comb
    begin
        en_out   = !v_out_reg || !out_stall;
        en.s4    = !v_s4_reg || en_out;
        en.s3    = !v_s3_reg || en.s4;
        en.s2    = !v_s2_reg || en.s3;
        en_s1    = !v_s1_reg || en.s2;
        in_stall = !en_s1;
    end

    always_comb
    begin
        ok_s1_next = (camera_index != qcpm_pkg::CAM_REJECT)
                     && (32'(center_x) >= -qcpm_pkg::IN_LIM_X)
                     && (32'(center_x) <= qcpm_pkg::IN_LIM_X)
                     && (32'(center_y) >= -qcpm_pkg::IN_LIM_Y)
                     && (32'(center_y) <= qcpm_pkg::IN_LIM_Y);
        xx_s2_next = qcpm_pkg::SQ_W'(x_s1_reg * x_s1_reg);
        xy_s2_next = qcpm_pkg::SQ_W'(x_s1_reg * y_s1_reg);
        yy_s2_next = qcpm_pkg::SQ_W'(y_s1_reg * y_s1_reg);
        cset_x_s1  = qcpm_pkg::coef_sel(cam_s1_reg == qcpm_pkg::CAM_BACK, 1'b0);
        cset_y_s1  = qcpm_pkg::coef_sel(cam_s1_reg == qcpm_pkg::CAM_BACK, 1'b1);
        cset_x_s2  = qcpm_pkg::coef_sel(cam_s2_reg == qcpm_pkg::CAM_BACK, 1'b0);
        cset_y_s2  = qcpm_pkg::coef_sel(cam_s2_reg == qcpm_pkg::CAM_BACK, 1'b1);
    end

    qcpm_axis u_axis_x (
        .clk     (clk),
        .en      (en),
        .cset_s1 (cset_x_s1),
        .cset_s2 (cset_x_s2),
        .x_s1    (x_s1_reg),
        .y_s1    (y_s1_reg),
        .xx_s2   (xx_s2_reg),
        .xy_s2   (xy_s2_reg),
        .yy_s2   (yy_s2_reg),
        .res     (res_x)
    );

    qcpm_axis u_axis_y (
        .clk     (clk),
        .en      (en),
        .cset_s1 (cset_y_s1),
        .cset_s2 (cset_y_s2),
        .x_s1    (x_s1_reg),
        .y_s1    (y_s1_reg),
        .xx_s2   (xx_s2_reg),
        .xy_s2   (xy_s2_reg),
        .yy_s2   (yy_s2_reg),
        .res     (res_y)
    );

    always_comb
    begin
        if (cam_s4_reg == qcpm_pkg::CAM_CENTER)
        begin
            px_sel = qcpm_pkg::RES_W'(x_s4_reg);
            py_sel = qcpm_pkg::RES_W'(y_s4_reg);
        end
        else
        begin
            px_sel = res_x;
            py_sel = res_y;
        end
        ok_out = ok_s4_reg
                 && (32'(px_sel) >= -qcpm_pkg::OUT_LIM_X)
                 && (32'(px_sel) <= qcpm_pkg::OUT_LIM_X)
                 && (32'(py_sel) >= -qcpm_pkg::OUT_LIM_Y)
                 && (32'(py_sel) <= qcpm_pkg::OUT_LIM_Y);
        point_valid_next = ok_out;
        projected_x_next = ok_out ? px_sel[qcpm_pkg::X_OUT_W-1:0] : '0;
        projected_y_next = ok_out ? py_sel[qcpm_pkg::Y_OUT_W-1:0] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_s1_reg  <= 1'b0;
            v_s2_reg  <= 1'b0;
            v_s3_reg  <= 1'b0;
            v_s4_reg  <= 1'b0;
            v_out_reg <= 1'b0;
        end
        else
        begin
            if (en_s1)
                v_s1_reg <= in_valid;
            if (en.s2)
                v_s2_reg <= v_s1_reg;
            if (en.s3)
                v_s3_reg <= v_s2_reg;
            if (en.s4)
                v_s4_reg <= v_s3_reg;
            if (en_out)
                v_out_reg <= v_s4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_s1)
        begin
            cam_s1_reg <= camera_index;
            ok_s1_reg  <= ok_s1_next;
            x_s1_reg   <= center_x;
            y_s1_reg   <= center_y;
        end
        if (en.s2)
        begin
            cam_s2_reg <= cam_s1_reg;
            ok_s2_reg  <= ok_s1_reg;
            x_s2_reg   <= x_s1_reg;
            y_s2_reg   <= y_s1_reg;
            xx_s2_reg  <= xx_s2_next;
            xy_s2_reg  <= xy_s2_next;
            yy_s2_reg  <= yy_s2_next;
        end
        if (en.s3)
        begin
            cam_s3_reg <= cam_s2_reg;
            ok_s3_reg  <= ok_s2_reg;
            x_s3_reg   <= x_s2_reg;
            y_s3_reg   <= y_s2_reg;
        end
        if (en.s4)
        begin
            cam_s4_reg <= cam_s3_reg;
            ok_s4_reg  <= ok_s3_reg;
            x_s4_reg   <= x_s3_reg;
            y_s4_reg   <= y_s3_reg;
        end
        if (en_out)
        begin
            point_valid_reg <= point_valid_next;
            projected_x_reg <= projected_x_next;
            projected_y_reg <= projected_y_next;
        end
    end

    assign out_valid   = v_out_reg;
    assign point_valid = point_valid_reg;
    assign projected_x = projected_x_reg;
    assign projected_y = projected_y_reg;

endmodule

// ===== design/qcpm_axis.sv =====
// Pipelined second-order polynomial for one output axis: products, coefficient
// products, quadratic sum, then rounding to the output grid. Depends on qcpm_pkg.
module qcpm_axis (
    input  logic                                   clk,
    input  qcpm_pkg::stage_en_t                    en,
    input  qcpm_pkg::coef_set_t                    cset_s1,
    input  qcpm_pkg::coef_set_t                    cset_s2,
    input  logic signed [qcpm_pkg::IN_W-1:0]       x_s1,
    input  logic signed [qcpm_pkg::IN_W-1:0]       y_s1,
    input  logic signed [qcpm_pkg::SQ_W-1:0]       xx_s2,
    input  logic signed [qcpm_pkg::SQ_W-1:0]       xy_s2,
    input  logic signed [qcpm_pkg::SQ_W-1:0]       yy_s2,
    output logic signed [qcpm_pkg::RES_W-1:0]      res
);

    logic signed [qcpm_pkg::LIN_W-1:0]  p1_s2_reg, p1_s2_next;
    logic signed [qcpm_pkg::LIN_W-1:0]  p2_s2_reg, p2_s2_next;
    logic signed [qcpm_pkg::LIN_W-1:0]  lin_s3_reg, lin_s3_next;
    logic signed [qcpm_pkg::QUAD_W-1:0] q3_s3_reg, q3_s3_next;
    logic signed [qcpm_pkg::QUAD_W-1:0] q4_s3_reg, q4_s3_next;
    logic signed [qcpm_pkg::QUAD_W-1:0] q5_s3_reg, q5_s3_next;
    logic signed [qcpm_pkg::LIN_W-1:0]  lin_s4_reg;
    logic signed [qcpm_pkg::QUAD_W-1:0] quad_s4_reg, quad_s4_next;
    logic signed [qcpm_pkg::SUM_W-1:0]  sum;

    localparam logic signed [qcpm_pkg::SUM_W-1:0] RND_HALF =
        qcpm_pkg::SUM_W'(64'sd1 <<< (qcpm_pkg::COEF_FB - 1));

    always_comb
    begin
        p1_s2_next   = qcpm_pkg::LIN_W'(cset_s1.c1 * x_s1);
        p2_s2_next   = qcpm_pkg::LIN_W'(cset_s1.c2 * y_s1);
        lin_s3_next  = (qcpm_pkg::LIN_W'(cset_s2.c0) <<< qcpm_pkg::FRAC_BITS)
                       + p1_s2_reg + p2_s2_reg;
        q3_s3_next   = qcpm_pkg::QUAD_W'(cset_s2.c3 * xx_s2);
        q4_s3_next   = qcpm_pkg::QUAD_W'(cset_s2.c4 * xy_s2);
        q5_s3_next   = qcpm_pkg::QUAD_W'(cset_s2.c5 * yy_s2);
        quad_s4_next = q3_s3_reg + q4_s3_reg + q5_s3_reg;
        sum          = qcpm_pkg::SUM_W'(lin_s4_reg)
                       + qcpm_pkg::SUM_W'(quad_s4_reg >>> qcpm_pkg::FRAC_BITS)
                       + RND_HALF;
        res          = sum[qcpm_pkg::SUM_W-1:qcpm_pkg::COEF_FB];
    end

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            p1_s2_reg <= p1_s2_next;
            p2_s2_reg <= p2_s2_next;
        end
        if (en.s3)
        begin
            lin_s3_reg <= lin_s3_next;
            q3_s3_reg  <= q3_s3_next;
            q4_s3_reg  <= q4_s3_next;
            q5_s3_reg  <= q5_s3_next;
        end
        if (en.s4)
        begin
            lin_s4_reg  <= lin_s3_reg;
            quad_s4_reg <= quad_s4_next;
        end
    end

endmodule

// ===== tb/tb.sv =====
// Testbench for quadratic_camera_point_mapper_core: directed and random camera points,
// checked against an in-bench fixed-point polynomial warp through a small scoreboard.
// Depends on qcpm_pkg and the RTL of the block only.
`timescale 1ns / 100ps

module tb;

    import qcpm_pkg::*;

    localparam longint PIX_ONE    = 64'sd1 <<< FRAC_BITS;
    localparam int     IN_HALF_X  = 140 << FRAC_BITS;
    localparam int     IN_HALF_Y  = 110 << FRAC_BITS;
    localparam int     OUT_HALF_X = 94 << FRAC_BITS;
    localparam int     OUT_HALF_Y = 60 << FRAC_BITS;
    localparam int     IN_SPAN    = 1 << IN_W;
    localparam int     ITEM_COUNT = 1450;
    localparam int     IDLE_LIMIT = 400;

    typedef struct {
        logic                        on_image;
        logic signed [X_OUT_W-1:0]   img_x;
        logic signed [Y_OUT_W-1:0]   img_y;
    } image_point_t;

    class point_map_board;
        longint       warp_q30 [4][6];
        image_point_t expected_points [$];
        int           errors;

        function new();
            longint digits [24];
            int     places [24];
            digits = '{64'sd4598873713, 64'sd1112662896, 64'sd3961500727,
                       -64'sd9593892413, 64'sd3638791921, 64'sd1953756646,
                       64'sd5776555674, -64'sd4623574104, 64'sd7418767472,
                       -64'sd3921243931, 64'sd9845932112, -64'sd3075629357,
                       -64'sd1182017882, -64'sd1112148871, 64'sd5965474006,
                       64'sd1312940857, 64'sd3580014712, -64'sd5696456455,
                       64'sd5842283122, -64'sd4773654331, -64'sd7173750546,
                       -64'sd3842275563, -64'sd4617931, -64'sd5021741498};
            places = '{9, 9, 11, 13, 12, 13,
                       8, 11, 10, 12, 14, 12,
                       8, 9, 11, 12, 12, 13,
                       8, 11, 10, 12, 10, 12};
            errors = 0;
            for (int i = 0; i < 24; i++)
                warp_q30[i / 6][i % 6] = decimal_to_q30(digits[i], places[i]);
        endfunction

        function longint decimal_to_q30(longint digits, int places);
            logic [95:0] scale;
            logic [95:0] mag;
            scale = 96'd1;
            repeat (places) scale = scale * 96'd10;
            mag = 96'(digits < 0 ? -digits : digits);
            mag = ((mag << 30) + (scale >> 1)) / scale;
            return digits < 0 ? -longint'(mag) : longint'(mag);
        endfunction

        function longint warp_axis(int set, longint x, longint y);
            longint lin;
            longint quad;
            longint sum;
            lin  = warp_q30[set][0] * PIX_ONE + warp_q30[set][1] * x + warp_q30[set][2] * y;
            quad = warp_q30[set][3] * (x * x) + warp_q30[set][4] * (x * y)
                 + warp_q30[set][5] * (y * y);
            sum  = lin + (quad >>> FRAC_BITS) + (64'sd1 <<< 29);
            return sum >>> 30;
        endfunction

        function void note_input(logic [1:0] cam, logic signed [IN_W-1:0] cx,
                                 logic signed [IN_W-1:0] cy);
            image_point_t want;
            longint x;
            longint y;
            longint px;
            longint py;
            logic   ok;
            x  = cx;
            y  = cy;
            px = 0;
            py = 0;
            ok = 1'b0;
            if (cam != CAM_REJECT && x >= -IN_HALF_X && x <= IN_HALF_X
                && y >= -IN_HALF_Y && y <= IN_HALF_Y)
            begin
                if (cam == CAM_CENTER)
                begin
                    px = x;
                    py = y;
                end
                else
                begin
                    px = warp_axis(cam == CAM_FRONT ? 0 : 2, x, y);
                    py = warp_axis(cam == CAM_FRONT ? 1 : 3, x, y);
                end
                ok = px >= -OUT_HALF_X && px <= OUT_HALF_X
                  && py >= -OUT_HALF_Y && py <= OUT_HALF_Y;
            end
            want.on_image = ok;
            want.img_x    = ok ? X_OUT_W'(px) : '0;
            want.img_y    = ok ? Y_OUT_W'(py) : '0;
            expected_points.insert(expected_points.size(), want);
        endfunction

        function int pending();
            return expected_points.size();
        endfunction

        task report(string what);
            errors++;
            $display("%0t mismatch: %s", $realtime, what);
        endtask

        task check_output(logic pv, logic signed [X_OUT_W-1:0] px,
                          logic signed [Y_OUT_W-1:0] py);
            image_point_t want;
            if (expected_points.size() == 0)
            begin
                report("result word with no input word pending");
                return;
            end
            want = expected_points.pop_front();
            if (pv !== want.on_image)
                report($sformatf("point_valid %b, want %b", pv, want.on_image));
            if (px !== want.img_x)
                report($sformatf("projected_x %0d, want %0d", px, want.img_x));
            if (py !== want.img_y)
                report($sformatf("projected_y %0d, want %0d", py, want.img_y));
        endtask
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    logic [1:0]                camera_index;
    logic signed [IN_W-1:0]    center_x;
    logic signed [IN_W-1:0]    center_y;
    logic                      out_valid;
    logic                      out_stall;
    logic                      point_valid;
    logic signed [X_OUT_W-1:0] projected_x;
    logic signed [Y_OUT_W-1:0] projected_y;

    point_map_board sb;
    logic           quiet;
    int             idle_cycles;

    quadratic_camera_point_mapper_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .camera_index (camera_index),
        .center_x     (center_x),
        .center_y     (center_y),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .point_valid  (point_valid),
        .projected_x  (projected_x),
        .projected_y  (projected_y)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int draw_wait();
        return quiet ? 0 : int'($urandom_range(0, 14));
    endfunction

    task automatic send_point(input logic [1:0] cam, input int x, input int y);
        int gap;
        gap = draw_wait();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        camera_index <= cam;
        center_x     <= x[IN_W-1:0];
        center_y     <= y[IN_W-1:0];
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic send_random();
        logic [1:0] cam;
        int         x;
        int         y;
        cam = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 99) < 15)
        begin
            x = int'($urandom_range(0, IN_SPAN - 1)) - IN_SPAN / 2;
            y = int'($urandom_range(0, IN_SPAN - 1)) - IN_SPAN / 2;
        end
        else
        begin
            x = int'($urandom_range(0, 2 * IN_HALF_X)) - IN_HALF_X;
            y = int'($urandom_range(0, 2 * IN_HALF_Y)) - IN_HALF_Y;
        end
        send_point(cam, x, y);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    initial
    begin
        int hold;
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            hold = draw_wait();
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_input(camera_index, center_x, center_y);
            if (out_valid && !out_stall)
                sb.check_output(point_valid, projected_x, projected_y);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tb NOT OK");
                $finish;
            end
        end
    end

    initial
    begin
        sb           = new();
        quiet        = 1'b0;
        idle_cycles  = 0;
        rst_n        = 1'b0;
        in_valid     <= 1'b0;
        camera_index <= CAM_FRONT;
        center_x     <= '0;
        center_y     <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_point(CAM_CENTER, 0, 0);
        send_point(CAM_FRONT, 0, 0);
        send_point(CAM_BACK, 0, 0);
        send_point(CAM_REJECT, 0, 0);
        send_point(CAM_CENTER, OUT_HALF_X, OUT_HALF_Y);
        send_point(CAM_CENTER, -OUT_HALF_X, -OUT_HALF_Y);
        send_point(CAM_CENTER, OUT_HALF_X + 1, 0);
        send_point(CAM_CENTER, 0, -OUT_HALF_Y - 1);
        send_point(CAM_FRONT, IN_HALF_X, IN_HALF_Y);
        send_point(CAM_FRONT, -IN_HALF_X, -IN_HALF_Y);
        send_point(CAM_BACK, IN_HALF_X, -IN_HALF_Y);
        send_point(CAM_BACK, -IN_HALF_X, IN_HALF_Y);
        send_point(CAM_FRONT, IN_HALF_X + 1, 0);
        send_point(CAM_BACK, 0, -IN_HALF_Y - 1);
        send_point(CAM_FRONT, -IN_SPAN / 2, -IN_SPAN / 2);
        send_point(CAM_BACK, IN_SPAN / 2 - 1, IN_SPAN / 2 - 1);
        send_point(CAM_REJECT, -IN_SPAN / 2, IN_SPAN / 2 - 1);
        send_point(CAM_CENTER, IN_SPAN / 2 - 1, -IN_SPAN / 2);
        send_point(CAM_FRONT, 1000, -2000);
        send_point(CAM_BACK, -3000, 4000);
        drain();

        for (int i = 0; i < ITEM_COUNT; i++)
        begin
            if (i % 100 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            if (i == ITEM_COUNT / 2)
                drain();
            send_random();
        end
        drain();
        repeat (8) @(posedge clk);

        if (sb.errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
